// ===== src/jdsl_pkg.sv =====
package jdsl_pkg;

	localparam int SAMPLE_BITS_DEF = 10;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 10;
	localparam int MID_W      = 10;
	localparam int DZ_W       = 9;
	localparam int HALF_W     = 10;
	localparam int STEP_W     = 8;
	localparam int DRIVE_W    = 8;
	localparam int DEN_W      = 10;
	localparam int QUO_W      = 9;
	localparam int MAG_W      = 7;
	localparam int SCALE_MAX  = 100;

	localparam logic [CFG_IDX_W-1:0] REG_STEER_MID  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VEL_MID    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_SCALE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INV_STEER  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_INV_VEL    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_STEER = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_VEL   = 3'd7;

	localparam logic [MID_W-1:0]  RST_MID        = 10'd512;
	localparam logic [DZ_W-1:0]   RST_DEAD_ZONE  = 9'd10;
	localparam logic [HALF_W-1:0] RST_HALF_SCALE = 10'd512;
	localparam logic [STEP_W-1:0] RST_STEP       = 8'd10;

	localparam logic AXIS_STEER = 1'b0;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ===== src/jdsl_div.sv =====
module jdsl_div #(
	parameter int NW = 18
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [NW-1:0]            num,
	input  logic [jdsl_pkg::DEN_W-1:0] den,
	output jdsl_pkg::div_stat_t      stat,
	output logic [jdsl_pkg::QUO_W-1:0] quo
);
	import jdsl_pkg::*;

	localparam int CW = $clog2(QUO_W);

	logic [NW-1:0]    rem_q;
	logic [NW-1:0]    ds_q;
	logic [QUO_W-1:0] quo_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic             ge;

	assign ge = (rem_q >= ds_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(QUO_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// one quotient bit per cycle, divisor shifts down
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			ds_q  <= NW'(den) << (QUO_W - 1);
			quo_q <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - ds_q;
			end
			quo_q <= {quo_q[QUO_W-2:0], ge};
			ds_q  <= ds_q >> 1;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quo       = quo_q;

endmodule

// ===== src/joystick_deadzone_slew_limiter.sv =====
// channel  | handshake                      | payload
// s_axis   | s_axis_tvalid / s_axis_tready  | tuser: op, tdata: raw_sample
// m_axis   | m_axis_tvalid / m_axis_tready  | tuser: axis, tdata: drive_value
// cfg      | cfg_valid / cfg_ready          | cfg_index, cfg_data
//
// a bit-serial divider scales the distance outside the dead band
// one item in flight; s_axis_tready is high only while waiting for a new item
// a held result stalls the final step until m_axis_tready frees the output register
// reset restores default registers and clears both previous outputs
module joystick_deadzone_slew_limiter #(
	parameter int SAMPLE_BITS = jdsl_pkg::SAMPLE_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]   s_axis_tdata,  // raw_sample
	input  logic                               s_axis_tuser,  // op
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [jdsl_pkg::DRIVE_W-1:0]       m_axis_tdata,  // drive_value
	output logic                               m_axis_tuser,  // axis
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [jdsl_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [jdsl_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import jdsl_pkg::*;

	localparam int EW = ((SAMPLE_BITS > 11) ? SAMPLE_BITS : 11) + 2;
	localparam int DW = ((SAMPLE_BITS > 10) ? SAMPLE_BITS : 10) + 1;
	localparam int NW = DW + 7;
	localparam int SW = 10;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_DIST = 5'b00010,
		ST_MUL  = 5'b00100,
		ST_DIV  = 5'b01000,
		ST_SLEW = 5'b10000
	} state_t;

	state_t state_q;

	logic [MID_W-1:0]  steer_mid_q;
	logic [MID_W-1:0]  vel_mid_q;
	logic [DZ_W-1:0]   dead_zone_q;
	logic [HALF_W-1:0] half_scale_q;
	logic              inv_steer_q;
	logic              inv_vel_q;
	logic [STEP_W-1:0] step_steer_q;
	logic [STEP_W-1:0] step_vel_q;

	logic signed [DRIVE_W-1:0] last_steer_q;
	logic signed [DRIVE_W-1:0] last_vel_q;

	logic                   axis_q;
	logic [SAMPLE_BITS-1:0] raw_q;
	logic [DW-1:0]          dist_q;
	logic                   neg_q;
	logic                   dpos_q;
	logic                   out_valid_q;
	logic [DRIVE_W-1:0]     out_data_q;
	logic                   out_axis_q;

	logic in_acc;
	logic out_load;

	// distance outside the dead band
	logic signed [EW-1:0] raw_e, mid_e, dz_e, hi_e, lo_e;
	logic [DW-1:0]        dist_d;
	logic                 neg_d;

	assign raw_e = $signed({{(EW-SAMPLE_BITS){1'b0}}, raw_q});
	assign mid_e = $signed({{(EW-MID_W){1'b0}}, (axis_q ? vel_mid_q : steer_mid_q)});
	assign dz_e  = $signed({{(EW-DZ_W){1'b0}}, dead_zone_q});
	assign hi_e  = mid_e + dz_e;
	assign lo_e  = mid_e - dz_e;

	always_comb begin
		priority if (raw_e > hi_e) begin
			dist_d = DW'(raw_e - hi_e);
			neg_d  = 1'b0;
		end else if (raw_e < lo_e) begin
			dist_d = DW'(lo_e - raw_e);
			neg_d  = 1'b1;
		end else begin
			dist_d = '0;
			neg_d  = 1'b0;
		end
	end

	// scale numerator and divisor
	logic [NW-1:0]        num_d;
	logic signed [11:0]   div_e;
	logic                 div_start;
	div_stat_t            div_stat;
	logic [QUO_W-1:0]     quo;

	assign num_d = NW'({dist_q, 6'b0}) + NW'({dist_q, 5'b0}) + NW'({dist_q, 2'b0});
	assign div_e = $signed({2'b0, half_scale_q}) - $signed({3'b0, dead_zone_q});
	assign div_start = (state_q == ST_MUL);

	jdsl_div #(
		.NW(NW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_d),
		.den    (div_e[DEN_W-1:0]),
		.stat   (div_stat),
		.quo    (quo)
	);

	// clamp, sign and slew limit
	logic [MAG_W-1:0]        mag;
	logic signed [SW-1:0]    tgt_e, prev_e, step_e, up_e, dn_e, res_e;

	assign mag    = (quo > QUO_W'(SCALE_MAX)) ? MAG_W'(SCALE_MAX) : quo[MAG_W-1:0];
	assign prev_e = SW'(axis_q ? last_vel_q : last_steer_q);
	assign step_e = $signed({2'b0, (axis_q ? step_vel_q : step_steer_q)});
	assign up_e   = prev_e + step_e;
	assign dn_e   = prev_e - step_e;

	always_comb begin
		if (!dpos_q) begin
			tgt_e = '0;
		end else if (neg_q) begin
			tgt_e = -$signed({3'b0, mag});
		end else begin
			tgt_e = $signed({3'b0, mag});
		end
		priority if (tgt_e > up_e) begin
			res_e = up_e;
		end else if (tgt_e < dn_e) begin
			res_e = dn_e;
		end else begin
			res_e = tgt_e;
		end
	end

	assign in_acc   = s_axis_tvalid && s_axis_tready;
	assign out_load = (state_q == ST_SLEW) && (!out_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) state_q <= ST_DIST;
				end
				ST_DIST: state_q <= ST_MUL;
				ST_MUL:  state_q <= ST_DIV;
				ST_DIV: begin
					if (div_stat.done) state_q <= ST_SLEW;
				end
				ST_SLEW: begin
					if (out_load) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			axis_q <= s_axis_tuser;
			raw_q  <= s_axis_tdata[SAMPLE_BITS-1:0];
		end
		if (state_q == ST_DIST) begin
			dist_q <= dist_d;
			neg_q  <= neg_d ^ (axis_q ? inv_vel_q : inv_steer_q);
		end
		if (state_q == ST_MUL) begin
			dpos_q <= (div_e > 12'sd0);
		end
		if (out_load) begin
			out_data_q <= res_e[DRIVE_W-1:0];
			out_axis_q <= axis_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			last_steer_q <= '0;
			last_vel_q   <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
				if (axis_q == AXIS_STEER) begin
					last_steer_q <= res_e[DRIVE_W-1:0];
				end else begin
					last_vel_q <= res_e[DRIVE_W-1:0];
				end
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steer_mid_q  <= RST_MID;
			vel_mid_q    <= RST_MID;
			dead_zone_q  <= RST_DEAD_ZONE;
			half_scale_q <= RST_HALF_SCALE;
			inv_steer_q  <= 1'b0;
			inv_vel_q    <= 1'b0;
			step_steer_q <= RST_STEP;
			step_vel_q   <= RST_STEP;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_STEER_MID:  steer_mid_q  <= cfg_data[MID_W-1:0];
				REG_VEL_MID:    vel_mid_q    <= cfg_data[MID_W-1:0];
				REG_DEAD_ZONE:  dead_zone_q  <= cfg_data[DZ_W-1:0];
				REG_HALF_SCALE: half_scale_q <= cfg_data[HALF_W-1:0];
				REG_INV_STEER:  inv_steer_q  <= cfg_data[0];
				REG_INV_VEL:    inv_vel_q    <= cfg_data[0];
				REG_STEP_STEER: step_steer_q <= cfg_data[STEP_W-1:0];
				REG_STEP_VEL:   step_vel_q   <= cfg_data[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_axis_q;
	assign cfg_ready     = 1'b1;

	a_accept_to_dist: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == ST_DIST))
		else $error("accepted item did not start");

	a_div_running: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (div_stat.busy || div_stat.done))
		else $error("waiting on an idle divider");

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !div_stat.busy)
		else $error("divider busy with no item");

	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ($signed(m_axis_tdata) >= -8'sd100 &&
			$signed(m_axis_tdata) <= 8'sd100))
		else $error("drive value out of range");

endmodule

// ===== test/tb_joystick_deadzone_slew_limiter.sv =====
`timescale 1ns / 1ps

module tb_joystick_deadzone_slew_limiter;
	import jdsl_pkg::*;

	localparam int  TDATA_W  = ((SAMPLE_BITS_DEF + 7) / 8) * 8;
	localparam int  RAW_MAX  = (1 << SAMPLE_BITS_DEF) - 1;
	localparam logic AXIS_VEL = ~AXIS_STEER;

	typedef struct packed {
		logic                       op;
		logic [SAMPLE_BITS_DEF-1:0] raw;
	} stick_sample_t;

	typedef struct packed {
		logic                      axis;
		logic signed [DRIVE_W-1:0] drive;
	} drive_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [TDATA_W-1:0]    s_axis_tdata = '0;  // raw_sample
	logic                  s_axis_tuser = AXIS_STEER;  // op
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [DRIVE_W-1:0]    m_axis_tdata;  // drive_value
	logic                  m_axis_tuser;  // axis
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_STEER_MID;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// register shadow and per-axis history
	logic [MID_W-1:0]          steer_mid_r = RST_MID;
	logic [MID_W-1:0]          vel_mid_r = RST_MID;
	logic [DZ_W-1:0]           dz_r = RST_DEAD_ZONE;
	logic [HALF_W-1:0]         half_r = RST_HALF_SCALE;
	logic                      inv_steer_r = 1'b0;
	logic                      inv_vel_r = 1'b0;
	logic [STEP_W-1:0]         step_steer_r = RST_STEP;
	logic [STEP_W-1:0]         step_vel_r = RST_STEP;
	logic signed [DRIVE_W-1:0] last_steer = '0;
	logic signed [DRIVE_W-1:0] last_vel = '0;

	stick_sample_t sample_q[$];
	drive_result_t drive_out_q[$];
	int            n_queued = 0;
	int            n_in = 0;
	int            n_out = 0;
	int            n_err = 0;
	int            n_settings = 0;
	int            tx_wait = 0;
	int            rx_stall = 0;
	logic          no_idle = 1'b0;

	joystick_deadzone_slew_limiter u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("tb_joystick_deadzone_slew_limiter NOT OK");
		$finish;
	end

	function automatic logic signed [DRIVE_W-1:0] slewed_drive(input logic [MID_W-1:0] raw,
		input logic [MID_W-1:0] mid, input logic inv, input logic [STEP_W-1:0] step,
		input logic signed [DRIVE_W-1:0] prev);
		int r, m, dz, den, span, pct, p, s;
		logic neg;
		r = int'(raw);
		m = int'(mid);
		dz = int'(dz_r);
		den = int'(half_r) - dz;
		p = int'(prev);
		s = int'(step);
		span = 0;
		neg = 1'b0;
		if (r > m + dz) begin
			span = r - m - dz;
		end else if (r < m - dz) begin
			span = m - dz - r;
			neg = 1'b1;
		end
		if (den <= 0) begin
			pct = 0;
		end else begin
			pct = (SCALE_MAX * span) / den;
			if (pct > SCALE_MAX)
				pct = SCALE_MAX;
			if (inv)
				neg = ~neg;
			if (neg)
				pct = -pct;
		end
		if (pct > p + s)
			pct = p + s;
		else if (pct < p - s)
			pct = p - s;
		return DRIVE_W'(pct);
	endfunction

	function automatic int pick_step();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 15);
			1: return 200;
			2: return 255;
			default: return $urandom_range(0, 255);
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		n_err++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_STEER_MID:  steer_mid_r = val[MID_W-1:0];
			REG_VEL_MID:    vel_mid_r = val[MID_W-1:0];
			REG_DEAD_ZONE:  dz_r = val[DZ_W-1:0];
			REG_HALF_SCALE: half_r = val[HALF_W-1:0];
			REG_INV_STEER:  inv_steer_r = val[0];
			REG_INV_VEL:    inv_vel_r = val[0];
			REG_STEP_STEER: step_steer_r = val[STEP_W-1:0];
			REG_STEP_VEL:   step_vel_r = val[STEP_W-1:0];
			default: ;
		endcase
	endtask

	task automatic write_all(input int mid_s, input int mid_v, input int dz, input int half,
		input int inv_s, input int inv_v, input int step_s, input int step_v);
		write_reg(REG_STEER_MID, CFG_DATA_W'(mid_s));
		write_reg(REG_VEL_MID, CFG_DATA_W'(mid_v));
		write_reg(REG_DEAD_ZONE, CFG_DATA_W'(dz));
		write_reg(REG_HALF_SCALE, CFG_DATA_W'(half));
		write_reg(REG_INV_STEER, CFG_DATA_W'(inv_s));
		write_reg(REG_INV_VEL, CFG_DATA_W'(inv_v));
		write_reg(REG_STEP_STEER, CFG_DATA_W'(step_s));
		write_reg(REG_STEP_VEL, CFG_DATA_W'(step_v));
		n_settings++;
		@(negedge clk);
	endtask

	task automatic queue_sample(input logic op, input int raw);
		stick_sample_t it;
		it.op = op;
		it.raw = SAMPLE_BITS_DEF'(raw);
		sample_q.push_back(it);
		n_queued++;
	endtask

	task automatic wait_idle();
		do @(negedge clk); while (n_in != n_queued || drive_out_q.size() != 0);
	endtask

	// sender: one item at a time, random gap counted while the block is ready
	always @(posedge clk or negedge arst_n) begin : drv
		stick_sample_t it;
		logic signed [DRIVE_W-1:0] d;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			tx_wait <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				if (s_axis_tuser == AXIS_STEER) begin
					d = slewed_drive(s_axis_tdata[SAMPLE_BITS_DEF-1:0], steer_mid_r,
						inv_steer_r, step_steer_r, last_steer);
					last_steer = d;
				end else begin
					d = slewed_drive(s_axis_tdata[SAMPLE_BITS_DEF-1:0], vel_mid_r,
						inv_vel_r, step_vel_r, last_vel);
					last_vel = d;
				end
				drive_out_q.push_back('{axis: s_axis_tuser, drive: d});
				n_in++;
			end
			if (s_axis_tvalid && !s_axis_tready) begin
				// hold the item
			end else if (tx_wait != 0) begin
				s_axis_tvalid <= 1'b0;
				if (s_axis_tready)
					tx_wait <= tx_wait - 1;
			end else if (sample_q.size() != 0) begin
				it = sample_q.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tuser <= it.op;
				s_axis_tdata <= TDATA_W'(it.raw);
				tx_wait <= no_idle ? 0 : $urandom_range(0, 8);
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// receiver: random stall counted while a result is offered
	always @(posedge clk or negedge arst_n) begin : mon
		drive_result_t want;
		int n;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			rx_stall <= 0;
		end else if (m_axis_tvalid && m_axis_tready) begin
			if (drive_out_q.size() == 0) begin
				report_mismatch($sformatf("result axis %0d drive %0d with no item waiting",
					m_axis_tuser, $signed(m_axis_tdata)));
			end else begin
				want = drive_out_q.pop_front();
				if (m_axis_tuser !== want.axis)
					report_mismatch($sformatf("axis %0d, want %0d", m_axis_tuser, want.axis));
				if (m_axis_tdata !== want.drive)
					report_mismatch($sformatf("drive %0d, want %0d (axis %0d)",
						$signed(m_axis_tdata), want.drive, want.axis));
			end
			n_out++;
			n = no_idle ? 0 : $urandom_range(0, 8);
			rx_stall <= n;
			m_axis_tready <= (n == 0);
		end else if (rx_stall != 0) begin
			if (m_axis_tvalid) begin
				rx_stall <= rx_stall - 1;
				m_axis_tready <= (rx_stall == 1);
			end
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	initial begin : main
		int m, v, k, run, mode;
		logic op;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset defaults
		queue_sample(AXIS_STEER, RAW_MAX);
		queue_sample(AXIS_STEER, RAW_MAX);
		queue_sample(AXIS_VEL, 0);
		queue_sample(AXIS_VEL, 0);
		queue_sample(AXIS_STEER, 512);
		queue_sample(AXIS_STEER, 522);
		queue_sample(AXIS_STEER, 523);
		queue_sample(AXIS_VEL, 501);
		wait_idle();

		// midpoints at the ends, tiny divisor, inverted, unlimited steps
		write_all(0, RAW_MAX, 0, 1, 1, 1, 255, 255);
		queue_sample(AXIS_STEER, 0);
		queue_sample(AXIS_STEER, RAW_MAX);
		queue_sample(AXIS_STEER, 1);
		queue_sample(AXIS_VEL, RAW_MAX);
		queue_sample(AXIS_VEL, 0);
		wait_idle();

		// dead zone above half scale, zero step on steering
		write_all(512, 512, 511, 0, 0, 0, 0, 200);
		queue_sample(AXIS_STEER, RAW_MAX);
		queue_sample(AXIS_VEL, 0);
		queue_sample(AXIS_VEL, RAW_MAX);
		wait_idle();

		// divisor exactly zero
		write_all(512, 512, 300, 300, 0, 0, 200, 200);
		queue_sample(AXIS_STEER, 0);
		queue_sample(AXIS_VEL, RAW_MAX);
		wait_idle();

		// band limits outside the sample range
		write_all(RAW_MAX, 0, 5, RAW_MAX, 0, 1, 1, 7);
		queue_sample(AXIS_STEER, 0);
		queue_sample(AXIS_VEL, RAW_MAX);
		queue_sample(AXIS_STEER, RAW_MAX);
		queue_sample(AXIS_VEL, 0);
		wait_idle();

		for (int p = 0; p < 12; p++) begin
			mode = $urandom_range(0, 3);
			write_all(mode == 0 ? $urandom_range(0, RAW_MAX) : $urandom_range(440, 584),
				mode == 0 ? $urandom_range(0, RAW_MAX) : $urandom_range(440, 584),
				mode == 1 ? $urandom_range(0, 1023) : $urandom_range(0, 40),
				mode == 2 ? $urandom_range(0, 1023) : $urandom_range(300, 560),
				$urandom_range(0, 1023), $urandom_range(0, 1023), pick_step(), pick_step());
			no_idle = (p % 4 == 3);
			k = 0;
			while (k < 103) begin
				op = $urandom_range(0, 1);
				run = $urandom_range(1, 12);
				for (int j = 0; j < run && k < 103; j++) begin
					m = (op == AXIS_STEER) ? int'(steer_mid_r) : int'(vel_mid_r);
					case ($urandom_range(0, 9))
						0, 1, 2: v = $urandom_range(0, RAW_MAX);
						3, 4, 5: v = m + ($urandom_range(0, 1) ? int'(dz_r) : -int'(dz_r))
							+ int'($urandom_range(0, 6)) - 3;
						6, 7, 8: v = m + int'($urandom_range(0, 2 * half_r)) - int'(half_r);
						default: v = $urandom_range(0, 1) ? RAW_MAX : 0;
					endcase
					if (v < 0)
						v = 0;
					if (v > RAW_MAX)
						v = RAW_MAX;
					queue_sample(op, v);
					k++;
				end
			end
			wait_idle();
		end

		repeat (40) @(posedge clk);
		if (drive_out_q.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", drive_out_q.size()));
		$display("run covered %0d samples under %0d register settings, %0d results checked",
			n_in, n_settings + 1, n_out);
		if (n_err == 0) begin
			$display("tb_joystick_deadzone_slew_limiter OK");
		end else begin
			$display("tb_joystick_deadzone_slew_limiter NOT OK");
		end
		$finish;
	end

endmodule
